### rtl/mvpg_pkg.sv
// Shared constants, register indexes and the channel state record of the pulse generator.
package mvpg_pkg;

  localparam int CHANNELS    = 4;
  localparam int COUNT_WIDTH = 24;
  localparam int BASE_WIDTH  = 16;
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CHAN_FIELD_W = 3;
  localparam int MIN_TICKS   = 2;
  localparam int DIV_CNT_W   = $clog2(COUNT_WIDTH + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int LEVEL_W    = 4;
  localparam int USED_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HT0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HT1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HT2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HT3    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEVELS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_USED   = 3'd6;

  localparam logic [BASE_WIDTH-1:0]  BASE_RESET   = 16'd10;
  localparam logic [COUNT_WIDTH-1:0] HT_RESET     = 24'd10;
  localparam logic [LEVEL_W-1:0]     LEVELS_RESET = 4'hf;

  // Item modes carried in tuser
  localparam logic MODE_TICK   = 1'b0;
  localparam logic MODE_ENABLE = 1'b1;

  // Per-channel record kept in the state RAM
  typedef struct packed {
    logic [COUNT_WIDTH-1:0] hi_cnt;
    logic [COUNT_WIDTH-1:0] lo_cnt;
    logic [COUNT_WIDTH-1:0] lo_ticks;
    logic                   enabled;
  } entry_t;

endpackage

### rtl/multi_channel_variable_period_pulse_gen.sv
// Top level: request sequencer of the four-channel variable-period pulse generator.
// Usage:
//   s_axis carries one request per item. tuser selects the kind: a base tick, or a
//   set-enable for one channel. A tick request carries the next period of every
//   channel; a channel that finishes its low phase while enabled takes its period.
//   m_axis returns one result per request: pin levels, the periods taken, and for
//   set-enable the previous enable and whether the channel number was valid.
//   The cfg port writes one register per cycle; write it only while idle, unenforced.
// Timing:
//   A tick walks the channels one at a time through the state RAM: read, then
//   modify and write back. A channel that starts a pulse converts period and
//   high time to ticks in two 24-step dividers run side by side, and waits for
//   them before the write-back. A tick ends with the finish step; a set-enable
//   reads, writes and finishes, or goes straight to finish when refused.
//   A new request is taken while the previous result still waits at m_axis.
// Reset: all channels stop with pins inactive; registers return to their defaults.
//   RAM entries not yet written read as zero through per-entry valid bits.
// Stall:
//   When m_axis is stalled the finished result holds and the next request waits
//   in its last step until the output register frees up.
module multi_channel_variable_period_pulse_gen
  import mvpg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // cfg write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // request stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // tdata: channel[2:0], enable[3], next_period_ch0[27:4], next_period_ch1[51:28],
  //        next_period_ch2[75:52], next_period_ch3[99:76], zero fill [103:100]
  input  logic [103:0]          s_axis_tdata_i,
  // tuser: mode[0]
  input  logic                  s_axis_tuser_i,
  // result stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // tdata: pin_levels[3:0], period_taken[7:4], previous_enable[8], channel_valid[9],
  //        zero fill [15:10]
  output logic [15:0]           m_axis_tdata_o
);

  localparam int EntryW = $bits(entry_t);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EX   = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  // Configuration registers
  logic [BASE_WIDTH-1:0]  base_q;
  logic [COUNT_WIDTH-1:0] ht_q [CHANNELS];
  logic [LEVEL_W-1:0]     lvl_q;
  logic [USED_W-1:0]      used_q;

  // Sequencer
  logic [2:0]             state_q, state_d;
  logic [CH_W-1:0]        ch_q, ch_d;
  logic                   mode_q;
  logic                   en_req_q;
  logic [COUNT_WIDTH-1:0] period_q [CHANNELS];
  entry_t                 work_q, work_d;
  logic [CHANNELS-1:0]    taken_q, taken_d;
  logic                   prev_q, prev_d;
  logic                   cvalid_q, cvalid_d;
  logic [CHANNELS-1:0]    active_q, active_d;
  logic [CHANNELS-1:0]    ent_vld_q;

  // Output register
  logic                   m_valid_q, m_valid_d;
  logic [15:0]            m_data_q, m_data_d;

  // RAM and dividers
  logic                   ram_we, ram_re;
  entry_t                 ram_wdata, ram_rdata, rd_ent;
  logic                   div_start;
  logic                   div_p_done, div_h_done;
  logic [COUNT_WIDTH-1:0] div_p_quot, div_h_quot;
  logic [BASE_WIDTH-1:0]  base_eff;

  // Request decode
  logic                   in_acc;
  logic [CHAN_FIELD_W-1:0] in_chan;
  logic [USED_W-1:0]      used_eff;
  logic                   chan_ok;
  logic                   out_free;

  // Pulse start arithmetic
  logic [COUNT_WIDTH-1:0] hticks, pticks, lticks;
  logic [CHANNELS-1:0]    pins;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_chan  = s_axis_tdata_i[2:0];
  assign used_eff = (used_q > USED_W'(CHANNELS)) ? USED_W'(CHANNELS) : used_q;
  assign chan_ok  = (in_chan != '0) && (in_chan <= CHAN_FIELD_W'(used_eff));
  assign base_eff = (base_q == '0) ? BASE_WIDTH'(1) : base_q;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE);

  // Entries never written read as the reset record
  assign rd_ent = ent_vld_q[ch_q] ? ram_rdata : '0;

  // High time is floored at one tick, period at the minimum tick count
  assign hticks = (div_h_quot == '0) ? COUNT_WIDTH'(1) : div_h_quot;
  assign pticks = (div_p_quot < COUNT_WIDTH'(MIN_TICKS)) ? COUNT_WIDTH'(MIN_TICKS)
                                                         : div_p_quot;
  assign lticks = (pticks > hticks) ? (pticks - hticks) : '0;

  assign pins = ~(active_q ^ lvl_q);

  always_comb begin
    state_d   = state_q;
    ch_d      = ch_q;
    work_d    = work_q;
    taken_d   = taken_q;
    prev_d    = prev_q;
    cvalid_d  = cvalid_q;
    active_d  = active_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_wdata = rd_ent;
    div_start = 1'b0;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          taken_d  = '0;
          prev_d   = 1'b0;
          cvalid_d = 1'b0;
          if (s_axis_tuser_i == MODE_ENABLE) begin
            ch_d    = CH_W'(in_chan - 1'b1);
            // refused channel: nothing changes
            state_d = chan_ok ? S_RD : S_FIN;
          end else begin
            ch_d    = '0;
            state_d = S_RD;
          end
        end
      end

      S_RD: begin
        ram_re  = 1'b1;
        state_d = S_EX;
      end

      S_EX: begin
        if (mode_q == MODE_ENABLE) begin
          ram_wdata.enabled = en_req_q;
          ram_we   = 1'b1;
          prev_d   = rd_ent.enabled;
          cvalid_d = 1'b1;
          state_d  = S_FIN;
        end else begin
          if (rd_ent.hi_cnt != '0) begin
            // active phase: count down, drop the pin at the end
            ram_wdata.hi_cnt = rd_ent.hi_cnt - 1'b1;
            if (rd_ent.hi_cnt == COUNT_WIDTH'(1)) begin
              active_d[ch_q]   = 1'b0;
              ram_wdata.lo_cnt = rd_ent.lo_ticks;
            end
            ram_we = 1'b1;
          end else begin
            if (rd_ent.lo_cnt != '0) begin
              ram_wdata.lo_cnt = rd_ent.lo_cnt - 1'b1;
            end
            if ((rd_ent.lo_cnt <= COUNT_WIDTH'(1)) && rd_ent.enabled) begin
              taken_d[ch_q] = 1'b1;
              if (period_q[ch_q] == '0) begin
                ram_wdata.enabled = 1'b0;
                ram_we = 1'b1;
              end else begin
                // hold the record while the dividers run
                work_d    = ram_wdata;
                div_start = 1'b1;
              end
            end else begin
              ram_we = 1'b1;
            end
          end

          if (div_start) begin
            state_d = S_DIV;
          end else if (ch_q == CH_W'(CHANNELS - 1)) begin
            state_d = S_FIN;
          end else begin
            ch_d    = ch_q + 1'b1;
            state_d = S_RD;
          end
        end
      end

      S_DIV: begin
        ram_wdata = work_q;
        if (div_p_done) begin
          ram_wdata.hi_cnt   = hticks;
          ram_wdata.lo_ticks = lticks;
          ram_we         = 1'b1;
          active_d[ch_q] = 1'b1;
          if (ch_q == CH_W'(CHANNELS - 1)) begin
            state_d = S_FIN;
          end else begin
            ch_d    = ch_q + 1'b1;
            state_d = S_RD;
          end
        end
      end

      S_FIN: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {6'b0, cvalid_q, prev_q, taken_q, pins};
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ch_q      <= '0;
      taken_q   <= '0;
      prev_q    <= 1'b0;
      cvalid_q  <= 1'b0;
      active_q  <= '0;
      ent_vld_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ch_q      <= ch_d;
      taken_q   <= taken_d;
      prev_q    <= prev_d;
      cvalid_q  <= cvalid_d;
      active_q  <= active_d;
      m_valid_q <= m_valid_d;
      if (ram_we) begin
        ent_vld_q[ch_q] <= 1'b1;
      end
    end
  end

  // Request payload and result data
  always_ff @(posedge clk_i) begin
    work_q   <= work_d;
    m_data_q <= m_data_d;
    if (in_acc) begin
      mode_q      <= s_axis_tuser_i;
      en_req_q    <= s_axis_tdata_i[3];
      period_q[0] <= s_axis_tdata_i[27:4];
      period_q[1] <= s_axis_tdata_i[51:28];
      period_q[2] <= s_axis_tdata_i[75:52];
      period_q[3] <= s_axis_tdata_i[99:76];
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RESET;
      ht_q   <= '{default: HT_RESET};
      lvl_q  <= LEVELS_RESET;
      used_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BASE:   base_q  <= cfg_wdata_i[BASE_WIDTH-1:0];
        REG_HT0:    ht_q[0] <= cfg_wdata_i[COUNT_WIDTH-1:0];
        REG_HT1:    ht_q[1] <= cfg_wdata_i[COUNT_WIDTH-1:0];
        REG_HT2:    ht_q[2] <= cfg_wdata_i[COUNT_WIDTH-1:0];
        REG_HT3:    ht_q[3] <= cfg_wdata_i[COUNT_WIDTH-1:0];
        REG_LEVELS: lvl_q   <= cfg_wdata_i[LEVEL_W-1:0];
        REG_USED:   used_q  <= cfg_wdata_i[USED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mvpg_ram #(
    .Width (EntryW),
    .Depth (CHANNELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ch_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ch_q),
    .rdata_o (ram_rdata)
  );

  // Period in ticks
  mvpg_div u_div_period (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (period_q[ch_q]),
    .divisor_i  (base_eff),
    .done_o     (div_p_done),
    .quot_o     (div_p_quot)
  );

  // High time in ticks
  mvpg_div u_div_high (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ht_q[ch_q]),
    .divisor_i  (base_eff),
    .done_o     (div_h_done),
    .quot_o     (div_h_quot)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

`ifndef ASSERT_OFF
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_EX || state_q == S_DIV))
    else $error("state RAM written outside a channel step");

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_p_done == div_h_done)
    else $error("period and high time dividers out of step");

  a_div_enters_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (state_q == S_DIV))
    else $error("divider started without waiting for it");

  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_RD || state_q == S_FIN))
    else $error("accepted request not sequenced");

  a_enable_no_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && mode_q == MODE_ENABLE) |-> (taken_q == '0))
    else $error("set-enable request reports a taken period");
`endif

endmodule

### rtl/mvpg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mvpg_ram #(
  parameter int Width = 8,
  parameter int Depth = 4,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/mvpg_div.sv
// Restoring divider, one quotient bit per cycle, for microseconds to base ticks.
module mvpg_div
  import mvpg_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [COUNT_WIDTH-1:0] dividend_i,
  input  logic [BASE_WIDTH-1:0]  divisor_i,
  output logic                   done_o,
  output logic [COUNT_WIDTH-1:0] quot_o
);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [BASE_WIDTH-1:0]  rem_q, rem_d;
  logic [BASE_WIDTH-1:0]  dvs_q, dvs_d;
  logic [COUNT_WIDTH-1:0] quo_q, quo_d;
  logic [BASE_WIDTH:0]    trial;
  logic                   fits;

  assign trial = {rem_q, quo_q[COUNT_WIDTH-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      rem_d = fits ? BASE_WIDTH'(trial - {1'b0, dvs_q}) : trial[BASE_WIDTH-1:0];
      quo_d = {quo_q[COUNT_WIDTH-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(COUNT_WIDTH - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
